### hdl/ofq_pkg.sv
// Shared types, constants and helpers for the overwriting frame queue.
// Used by ofq_regs, ofq_ctrl, ofq_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ofq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int FRAME_BYTES = 64;

  localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int BIDX_W    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int MEM_AW    = SLOT_W + BIDX_W;
  localparam int MEM_DEPTH = QUEUE_DEPTH * (1 << BIDX_W);
  localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 4;
  localparam int ROOM_W   = 7;
  localparam int ADDR_W   = 2;
  localparam int DATA_W   = 32;

  localparam logic [LEN_W-1:0]  MAX_LEN_RESET    = 7'd64;
  localparam logic [ADDR_W-1:0] REG_MAX_LEN_ADDR = 2'd0;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED  = 3'd0,
    STAT_DROPPED = 3'd1,
    STAT_BYTE    = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_ROOM    = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic push;
    logic pop_empty;
    logic pop_short;
    logic pop_start;
    logic stream;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_full;
    logic queue_empty;
    logic room_short;
    logic last_byte;
  } dp_status_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = SLOT_W'(s + 1'b1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/overwriting_frame_queue_unit.sv
// Overwriting frame queue: push one byte per cycle while in_stall is low; a push that
// ends a frame gives its result in the cycle after acceptance. A pop on an empty queue
// or with too little room answers in the cycle after acceptance. A pop of an L-byte frame
// latches the slot, then reads one byte per cycle into the result register unless out_stall
// holds it; in_stall stays high until the last byte is loaded. Synchronous active-low reset
// clears pointers, counts and the limit register (to 64); no memory clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_frame_queue_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [ofq_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_end_of_frame,
  input  logic [ofq_pkg::ROOM_W-1:0]    in_buffer_room,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ofq_pkg::STATUS_W-1:0]  out_status,
  output logic [ofq_pkg::BYTE_W-1:0]    out_byte_out,
  output logic                          out_last,
  output logic [ofq_pkg::LEN_W-1:0]     out_frame_length,
  output logic [ofq_pkg::COUNT_W-1:0]   out_frame_count,
  output logic                          out_truncated,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ofq_pkg::ADDR_W-1:0]    paddr,
  input  logic [ofq_pkg::DATA_W-1:0]    pwdata,
  output logic [ofq_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import ofq_pkg::*;

  ctl_cmd_t         cmd;
  dp_status_t       st;
  logic [LEN_W-1:0] limit;

  ofq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  ofq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_stall  (out_stall),
    .st         (st),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  ofq_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_data_byte     (in_data_byte),
    .in_end_of_frame  (in_end_of_frame),
    .in_buffer_room   (in_buffer_room),
    .limit            (limit),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_byte_out     (out_byte_out),
    .out_last         (out_last),
    .out_frame_length (out_frame_length),
    .out_frame_count  (out_frame_count),
    .out_truncated    (out_truncated)
  );

endmodule

`default_nettype wire

### hdl/ofq_regs.sv
// APB-style register port holding the frame length limit.
// Depends on ofq_pkg; drives the saturated limit into the datapath.
`timescale 1ns / 1ps
`default_nettype none

module ofq_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ofq_pkg::ADDR_W-1:0] paddr,
  input  logic [ofq_pkg::DATA_W-1:0] pwdata,
  output logic [ofq_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [ofq_pkg::LEN_W-1:0]  limit
);
  import ofq_pkg::*;

  logic [LEN_W-1:0] max_len_r;
  logic [LEN_W-1:0] max_len_nxt;

  always_comb begin
    max_len_nxt = max_len_r;
    if (psel && penable && pwrite) begin
      max_len_nxt = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  // saturate into 1..FRAME_BYTES
  always_comb begin
    if (max_len_r == '0) begin
      limit = LEN_W'(1);
    end else if (max_len_r > LEN_W'(FRAME_BYTES)) begin
      limit = LEN_W'(FRAME_BYTES);
    end else begin
      limit = max_len_r;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_LEN_ADDR) ? DATA_W'(max_len_r) : '0;

endmodule

`default_nettype wire

### hdl/ofq_ctrl.sv
// Controller state machine: accepts beats and sequences frame streaming.
// Depends on ofq_pkg; issues commands to and reads status from ofq_datapath.
`timescale 1ns / 1ps
`default_nettype none

module ofq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_command,
  input  logic                  out_stall,
  input  ofq_pkg::dp_status_t   st,
  output logic                  in_stall,
  output ofq_pkg::ctl_cmd_t     cmd
);
  import ofq_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   can_load;

  assign can_load = !st.out_full || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !can_load;
        if (in_valid && can_load) begin
          if (in_command == CMD_PUSH) begin
            cmd.push = 1'b1;
          end else if (st.queue_empty) begin
            cmd.pop_empty = 1'b1;
          end else if (st.room_short) begin
            cmd.pop_short = 1'b1;
          end else begin
            cmd.pop_start = 1'b1;
            state_nxt     = ST_STREAM;
          end
        end
      end
      ST_STREAM: begin
        if (can_load) begin
          cmd.stream = 1'b1;
          if (st.last_byte) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/ofq_datapath.sv
// Datapath: frame memory, slot lengths, ring pointers and the result register.
// Depends on ofq_pkg; driven by commands from ofq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ofq_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ofq_pkg::ctl_cmd_t             cmd,
  output ofq_pkg::dp_status_t           st,
  input  logic [ofq_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_end_of_frame,
  input  logic [ofq_pkg::ROOM_W-1:0]    in_buffer_room,
  input  logic [ofq_pkg::LEN_W-1:0]     limit,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [ofq_pkg::STATUS_W-1:0]  out_status,
  output logic [ofq_pkg::BYTE_W-1:0]    out_byte_out,
  output logic                          out_last,
  output logic [ofq_pkg::LEN_W-1:0]     out_frame_length,
  output logic [ofq_pkg::COUNT_W-1:0]   out_frame_count,
  output logic                          out_truncated
);
  import ofq_pkg::*;

  logic [BYTE_W-1:0] mem [MEM_DEPTH];
  logic [LEN_W-1:0]  slot_len [QUEUE_DEPTH];

  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [LEN_W-1:0]  wr_off_r, wr_off_nxt;
  logic              cut_r, cut_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]  str_idx_r, str_idx_nxt;

  logic [SLOT_W-1:0] str_slot_r;
  logic [LEN_W-1:0]  str_len_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              byte_sel_r;
  status_t           status_r, status_nxt;
  logic              last_r, last_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [OCC_W-1:0]  count_r, count_nxt;
  logic              trunc_r, trunc_nxt;

  logic              fits;
  logic              full;
  logic              commit;
  logic              load;
  logic [LEN_W-1:0]  commit_len;
  logic              commit_cut;
  logic [MEM_AW-1:0] wr_addr;
  logic [MEM_AW-1:0] rd_addr;

  assign fits       = wr_off_r < limit;
  assign full       = occ_r == OCC_W'(QUEUE_DEPTH);
  assign commit     = cmd.push && in_end_of_frame;
  assign commit_len = fits ? LEN_W'(wr_off_r + 1'b1) : wr_off_r;
  assign commit_cut = cut_r || !fits;
  assign wr_addr    = {wr_slot_r, wr_off_r[BIDX_W-1:0]};
  assign rd_addr    = {str_slot_r, str_idx_r[BIDX_W-1:0]};
  assign load       = commit || cmd.pop_empty || cmd.pop_short || cmd.stream;

  assign st.out_full    = out_valid_r;
  assign st.queue_empty = occ_r == '0;
  assign st.room_short  = in_buffer_room < slot_len[rd_slot_r];
  assign st.last_byte   = LEN_W'(str_idx_r + 1'b1) == str_len_r;

  always_comb begin
    wr_slot_nxt   = wr_slot_r;
    rd_slot_nxt   = rd_slot_r;
    occ_nxt       = occ_r;
    wr_off_nxt    = wr_off_r;
    cut_nxt       = cut_r;
    str_idx_nxt   = str_idx_r;
    status_nxt    = status_r;
    last_nxt      = 1'b1;
    len_nxt       = len_r;
    count_nxt     = count_r;
    trunc_nxt     = 1'b0;
    if (cmd.push) begin
      if (in_end_of_frame) begin
        wr_slot_nxt = next_slot(wr_slot_r);
        wr_off_nxt  = '0;
        cut_nxt     = 1'b0;
        len_nxt     = commit_len;
        trunc_nxt   = commit_cut;
        if (full) begin
          rd_slot_nxt = next_slot(rd_slot_r);
          status_nxt  = STAT_DROPPED;
        end else begin
          occ_nxt    = OCC_W'(occ_r + 1'b1);
          status_nxt = STAT_STORED;
        end
        count_nxt = occ_nxt;
      end else begin
        wr_off_nxt = commit_len;
        cut_nxt    = commit_cut;
      end
    end
    if (cmd.pop_empty) begin
      status_nxt = STAT_EMPTY;
      len_nxt    = '0;
      count_nxt  = occ_r;
    end
    if (cmd.pop_short) begin
      status_nxt = STAT_ROOM;
      len_nxt    = slot_len[rd_slot_r];
      count_nxt  = occ_r;
    end
    if (cmd.pop_start) begin
      rd_slot_nxt = next_slot(rd_slot_r);
      occ_nxt     = OCC_W'(occ_r - 1'b1);
      str_idx_nxt = '0;
    end
    if (cmd.stream) begin
      status_nxt  = STAT_BYTE;
      last_nxt    = st.last_byte;
      len_nxt     = str_len_r;
      count_nxt   = occ_r;
      str_idx_nxt = LEN_W'(str_idx_r + 1'b1);
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r   <= '0;
      rd_slot_r   <= '0;
      occ_r       <= '0;
      wr_off_r    <= '0;
      cut_r       <= 1'b0;
      out_valid_r <= 1'b0;
      str_idx_r   <= '0;
    end else begin
      wr_slot_r   <= wr_slot_nxt;
      rd_slot_r   <= rd_slot_nxt;
      occ_r       <= occ_nxt;
      wr_off_r    <= wr_off_nxt;
      cut_r       <= cut_nxt;
      out_valid_r <= out_valid_nxt;
      str_idx_r   <= str_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r   <= status_nxt;
      last_r     <= last_nxt;
      len_r      <= len_nxt;
      count_r    <= count_nxt;
      trunc_r    <= trunc_nxt;
      byte_sel_r <= cmd.stream;
    end
    if (cmd.pop_start) begin
      str_slot_r <= rd_slot_r;
      str_len_r  <= slot_len[rd_slot_r];
    end
    if (commit) begin
      slot_len[wr_slot_r] <= commit_len;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && fits) begin
      mem[wr_addr] <= in_data_byte;
    end
    if (cmd.stream) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_byte_out     = byte_sel_r ? rd_data_r : '0;
  assign out_last         = last_r;
  assign out_frame_length = len_r;
  assign out_frame_count  = COUNT_W'(count_r);
  assign out_truncated    = trunc_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_stream_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stream |=> out_valid_r && status_r == STAT_BYTE)
    else $error("streamed byte not presented");

  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_start |=> OCC_W'(occ_r + 1'b1) == $past(occ_r))
    else $error("pop did not release a slot");

  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && last_r && !byte_sel_r)
    else $error("commit gave no final result");
`endif

endmodule

`default_nettype wire
